[rtl/tts_pkg.sv]
// Shared types, character codes and stop-word match for the tokenizer core.
// No dependencies; the core and the cell import it.
package tts_pkg;

   // Control handed from the sequencer to each character cell.
   typedef struct packed {
      logic load;   // write the incoming character into this cell
      logic shift;  // take the neighbour's character
   } cell_ctl_type;

   typedef logic [7:0] char_type;

   // Register indexes on the csr port (byte address = 4 * index).
   localparam logic [1:0] REG_LOWERCASE = 2'd0;
   localparam logic [1:0] REG_STOP      = 2'd1;
   localparam logic [1:0] REG_STEM      = 2'd2;

   localparam char_type CH_UC_A = 8'h41;
   localparam char_type CH_UC_Z = 8'h5A;
   localparam char_type CH_LC_A = 8'h61;
   localparam char_type CH_LC_Z = 8'h7A;
   localparam char_type CH_0    = 8'h30;
   localparam char_type CH_9    = 8'h39;
   localparam char_type CH_D    = 8'h64;
   localparam char_type CH_E    = 8'h65;
   localparam char_type CH_F    = 8'h66;
   localparam char_type CH_G    = 8'h67;
   localparam char_type CH_H    = 8'h68;
   localparam char_type CH_I    = 8'h69;
   localparam char_type CH_N    = 8'h6E;
   localparam char_type CH_O    = 8'h6F;
   localparam char_type CH_S    = 8'h73;
   localparam char_type CH_T    = 8'h74;

   localparam char_type CASE_OFFSET = 8'h20;

   function automatic logic is_alnum(input char_type c);
      logic lc, uc, dg;
      lc = (c >= CH_LC_A) && (c <= CH_LC_Z);
      uc = (c >= CH_UC_A) && (c <= CH_UC_Z);
      dg = (c >= CH_0) && (c <= CH_9);
      return lc || uc || dg;
   endfunction

   // n is the token length, valid only when the token is at most 3 long.
   function automatic logic is_stop_word(input logic [1:0] n, input char_type c0,
                                         input char_type c1, input char_type c2);
      logic hit;
      hit = 1'b0;
      unique case (n)
         2'd1: hit = (c0 == CH_LC_A);
         2'd2: hit = (c0 == CH_I && c1 == CH_S) || (c0 == CH_LC_A && c1 == CH_N) ||
                     (c0 == CH_I && c1 == CH_N) || (c0 == CH_O && c1 == CH_F) ||
                     (c0 == CH_T && c1 == CH_O);
         2'd3: hit = (c0 == CH_T && c1 == CH_H && c2 == CH_E) ||
                     (c0 == CH_LC_A && c1 == CH_N && c2 == CH_D);
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

[rtl/text_tokenizer_stopword_stemmer_core.sv]
// Top level of the tokenizer with stop-word filter and suffix stemmer.
// Depends on tts_pkg and tts_cell.
//
//  channel | direction | tdata / data                         | side band
//  req     | in        | [7:0] char_in                        | tuser = new_set
//  rsp     | out       | [7:0] token_char, [16:8] token_index | tlast = last_char
//  csr     | in/out    | 0x0 lowercase, 0x4 stop, 0x8 stem    | pready tied high
//
// A byte that closes a kept token starts a drain of the character row,
// one character per cycle while rsp is not stalled, until all n characters
// of the result are sent.
// Reset clears counts, length, the csr bits (to 1) and the output valid.
// Stalls: a held rsp transfer freezes the drain; req is refused while draining.
module text_tokenizer_stopword_stemmer_core import tts_pkg::*; #(
   parameter int TOKEN_CHARS     = 63,
   parameter int MAX_TOKEN_COUNT = 512
) (
   input  logic        clock,
   input  logic        reset,
   // req
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tuser,   // [0] new_set
   // rsp
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] token_char, [16:8] token_index, rest zero
   output logic        rsp_tlast,
   // csr
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int LEN_W = $clog2(TOKEN_CHARS + 1);
   localparam int RAW_W = $clog2(MAX_TOKEN_COUNT + 1);

   typedef enum logic {ST_GATHER, ST_DRAIN} state_type;

   // ---------------------------------------------------------------- csr
   logic lower_ff, stop_ff, stem_ff;
   logic lower_in, stop_in, stem_in;
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      lower_in = lower_ff;
      stop_in  = stop_ff;
      stem_in  = stem_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_LOWERCASE: lower_in = csr_pwdata[0];
            REG_STOP:      stop_in  = csr_pwdata[0];
            REG_STEM:      stem_in  = csr_pwdata[0];
            default: ;  // beyond the register list: drop
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[3:2])
         REG_LOWERCASE: csr_prdata[0] = lower_ff;
         REG_STOP:      csr_prdata[0] = stop_ff;
         REG_STEM:      csr_prdata[0] = stem_ff;
         default:       csr_prdata    = '0;
      endcase
   end

   // ---------------------------------------------------------- sequencer
   state_type        state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;       // characters gathered so far
   logic [LEN_W-1:0] rem_ff, rem_in;       // characters still to drain
   logic [RAW_W-1:0] raw_ff, raw_in;       // tokens closed in this set
   logic [8:0]       kept_ff, kept_in;     // kept token count, modulo 512
   logic [8:0]       tok_idx_ff, tok_idx_in;
   char_type         tail1_ff, tail2_ff, tail3_ff;  // last three stored chars
   char_type         tail1_in, tail2_in, tail3_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_last_ff, rsp_last_in;
   char_type         rsp_char_ff, rsp_char_in;
   logic [8:0]       rsp_idx_ff, rsp_idx_in;

   logic             req_acc;
   logic             drain_step;
   char_type         c_fold;
   logic             c_alnum;
   logic [LEN_W-1:0] len_eff;
   logic [RAW_W-1:0] raw_eff;
   logic [8:0]       kept_eff;
   logic             store_ok;
   logic             stop_hit;
   logic [LEN_W-1:0] stem_len;
   char_type         row_char [TOKEN_CHARS];

   assign req_tready = (state_ff == ST_GATHER);
   assign req_acc    = req_tvalid && req_tready;
   assign drain_step = (state_ff == ST_DRAIN) && (!rsp_valid_ff || rsp_tready);

   // Fold case, then treat new_set as a clear that happens before the byte.
   always_comb begin
      c_fold = req_tdata;
      if (lower_ff && req_tdata >= CH_UC_A && req_tdata <= CH_UC_Z) begin
         c_fold = req_tdata + CASE_OFFSET;
      end
      c_alnum  = is_alnum(c_fold);
      len_eff  = req_tuser ? '0 : len_ff;
      raw_eff  = req_tuser ? '0 : raw_ff;
      kept_eff = req_tuser ? '0 : kept_ff;
      store_ok = (len_eff < LEN_W'(TOKEN_CHARS));
   end

   // Judge the closing token on its first three and last three characters.
   always_comb begin
      stop_hit = stop_ff && (len_eff <= LEN_W'(3)) &&
                 is_stop_word(len_eff[1:0], row_char[0], row_char[1], row_char[2]);
      stem_len = len_eff;
      if (stem_ff) begin
         priority if (len_eff > LEN_W'(3) && tail3_ff == CH_I && tail2_ff == CH_N &&
                      tail1_ff == CH_G) begin
            stem_len = len_eff - LEN_W'(3);
         end else if (len_eff > LEN_W'(2) && tail2_ff == CH_E && tail1_ff == CH_D) begin
            stem_len = len_eff - LEN_W'(2);
         end else if (len_eff > LEN_W'(1) && tail1_ff == CH_S) begin
            stem_len = len_eff - LEN_W'(1);
         end else begin
            stem_len = len_eff;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      raw_in       = raw_ff;
      kept_in      = kept_ff;
      tok_idx_in   = tok_idx_ff;
      tail1_in     = tail1_ff;
      tail2_in     = tail2_ff;
      tail3_in     = tail3_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_last_in  = rsp_last_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_idx_in   = rsp_idx_ff;

      unique case (state_ff)
         ST_GATHER: begin
            if (req_acc) begin
               raw_in  = raw_eff;
               kept_in = kept_eff;
               if (c_alnum) begin
                  len_in = len_eff;
                  if (store_ok) begin
                     len_in   = len_eff + LEN_W'(1);
                     tail1_in = c_fold;
                     tail2_in = tail1_ff;
                     tail3_in = tail2_ff;
                  end
               end else begin
                  // Delimiter: close the token and decide whether it is sent.
                  len_in = '0;
                  if (len_eff != '0 && raw_eff < RAW_W'(MAX_TOKEN_COUNT)) begin
                     raw_in = raw_eff + RAW_W'(1);
                     if (!stop_hit) begin
                        kept_in    = kept_eff + 9'd1;
                        tok_idx_in = kept_eff;
                        rem_in     = stem_len;
                        state_in   = ST_DRAIN;
                     end
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (drain_step) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = row_char[0];
               rsp_idx_in   = tok_idx_ff;
               rsp_last_in  = (rem_ff == LEN_W'(1));
               rem_in       = rem_ff - LEN_W'(1);
               if (rem_ff == LEN_W'(1)) begin
                  state_in = ST_GATHER;
               end
            end
         end
         default: state_in = ST_GATHER;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_GATHER;
         len_ff       <= '0;
         rem_ff       <= '0;
         raw_ff       <= '0;
         kept_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         lower_ff     <= 1'b1;
         stop_ff      <= 1'b1;
         stem_ff      <= 1'b1;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rem_ff       <= rem_in;
         raw_ff       <= raw_in;
         kept_ff      <= kept_in;
         rsp_valid_ff <= rsp_valid_in;
         lower_ff     <= lower_in;
         stop_ff      <= stop_in;
         stem_ff      <= stem_in;
      end
   end

   // Payload: no reset needed.
   always_ff @(posedge clock) begin
      tok_idx_ff  <= tok_idx_in;
      tail1_ff    <= tail1_in;
      tail2_ff    <= tail2_in;
      tail3_ff    <= tail3_in;
      rsp_last_ff <= rsp_last_in;
      rsp_char_ff <= rsp_char_in;
      rsp_idx_ff  <= rsp_idx_in;
   end

   // ------------------------------------------------------- character row
   // Gather writes the cell addressed by the length; drain shifts the row
   // one place towards cell 0 and sends cell 0.
   for (genvar i = 0; i < TOKEN_CHARS; i++) begin : g_cell
      cell_ctl_type ctl;
      char_type     next_char;

      assign ctl.load  = req_acc && c_alnum && store_ok && (len_eff == LEN_W'(i));
      assign ctl.shift = drain_step;

      if (i == TOKEN_CHARS - 1) begin : g_end
         assign next_char = '0;
      end else begin : g_mid
         assign next_char = row_char[i + 1];
      end

      tts_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .new_char  (c_fold),
         .next_char (next_char),
         .char_out  (row_char[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_idx_ff, rsp_char_ff};

endmodule

[rtl/tts_cell.sv]
// One character cell of the token row: loads a new character or takes its
// neighbour's. Depends on tts_pkg.
module tts_cell import tts_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  char_type     new_char,
   input  char_type     next_char,
   output char_type     char_out
);

   char_type char_ff;
   char_type char_in;

   always_comb begin
      char_in = char_ff;
      if (ctl.load) begin
         char_in = new_char;
      end else if (ctl.shift) begin
         char_in = next_char;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

   assign char_out = char_ff;

endmodule

[rtl/tts_checker.sv]
// Port-level checks for the tokenizer core, bound to the top level.
// No dependencies.
module tts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transfer changed while stalled");

   // Refuse input while a token is still partly sent.
   a_no_req_mid_token: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("req accepted in the middle of a token");

   // Characters of one token carry the same index.
   a_index_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast ##1 rsp_tvalid
      |-> rsp_tdata[16:8] == $past(rsp_tdata[16:8]))
      else $error("token index changed inside a token");

   // Drop any result on reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind text_tokenizer_stopword_stemmer_core tts_checker u_tts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

[tb/tb_text_tokenizer_stopword_stemmer_core.sv]
`timescale 1ns / 1ps
// Self-checking bench for text_tokenizer_stopword_stemmer_core: streams document bytes
// into req and checks every rsp transfer against a built-in tokenizer model.
// Depends on tts_pkg and the core; needs nothing else.
module tb_text_tokenizer_stopword_stemmer_core;
   import tts_pkg::*;

   localparam int TOK_MAX       = 63;    // characters held per token
   localparam int TOK_LIMIT     = 512;   // raw tokens counted before the cap bites
   localparam int IDLE_LIMIT    = 4000;  // cycles without any transfer before giving up
   localparam int SETTLE_CYCLES = 12;    // let a byte with no result finish before a csr write
   localparam int TAIL_CYCLES   = 20;
   localparam int CFG_KEEP      = -1;
   localparam int NO_END        = -1;
   localparam logic [1:0] REG_SPARE = 2'd3;  // unmapped index, writes must be ignored

   typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_RUNS, READY_BEAT} ready_mode_type;

   typedef struct packed {
      char_type   ch;
      logic       last;
      logic [8:0] idx;
   } token_char_type;

   // One directed row: optional settings, a run of fill bytes, some text, an optional
   // trailing byte; new_set rides on the first byte.  Typed rows carry their result.
   typedef struct {
      bit       ns;
      int       cfg;
      char_type fill;
      int       fill_n;
      string    text;
      int       tail;
      bit       typed;
      string    want;
      int       want_idx;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] char_in
   logic        req_tuser = 1'b0; // [0] new_set
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [7:0] token_char, [16:8] token_index, rest zero
   logic        rsp_tlast;        // last_char
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   text_tokenizer_stopword_stemmer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Tokenizer model: private copy of the character row, counts and settings.
   // ---------------------------------------------------------------------------------
   char_type       tok_buf [TOK_MAX];
   int             tok_len, raw_count, kept_count;
   logic           fold_on, filter_on, stem_on;
   string          stop_vocab [8];
   string          suffixes [5];
   token_char_type step_out [$];      // characters released by the latest byte
   token_char_type pending_chars [$]; // characters still owed by the core, oldest first

   function automatic bit word_char(input char_type c);
      return c inside {[CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z], [CH_0:CH_9]};
   endfunction

   // True when the row holds s starting at pos.
   function automatic bit buf_holds(input int pos, input string s);
      for (int i = 0; i < s.len(); i++)
         if (tok_buf[pos + i] != s[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void tokenize_byte(input char_type c_in, input logic ns);
      char_type c;
      int       n;
      c = c_in;
      step_out.delete();
      // new_set wipes counts and any half-gathered token before the byte is seen
      if (ns) begin
         raw_count  = 0;
         kept_count = 0;
         tok_len    = 0;
      end
      if (fold_on && c inside {[CH_UC_A:CH_UC_Z]}) c = c + CASE_OFFSET;
      if (word_char(c)) begin
         // overlong tokens: drop everything past the row's end
         if (tok_len < TOK_MAX) begin
            tok_buf[tok_len] = c;
            tok_len++;
         end
         return;
      end
      n = tok_len;
      tok_len = 0;
      // empty token, or the cap has been reached: nothing counted, nothing sent
      if (n == 0 || raw_count >= TOK_LIMIT) return;
      raw_count++;
      if (filter_on)
         foreach (stop_vocab[w])
            if (stop_vocab[w].len() == n && buf_holds(0, stop_vocab[w])) return;
      if (stem_on) begin
         if (n > 3 && buf_holds(n - 3, "ing")) n -= 3;
         else if (n > 2 && buf_holds(n - 2, "ed")) n -= 2;
         else if (n > 1 && buf_holds(n - 1, "s")) n -= 1;
      end
      for (int k = 0; k < n; k++)
         step_out.push_back('{tok_buf[k], k == n - 1, 9'(kept_count)});
      kept_count++;
   endfunction

   // ---------------------------------------------------------------------------------
   // Result checker: compare every rsp transfer with the oldest owed character.
   // ---------------------------------------------------------------------------------
   int checked = 0;
   int fail_count = 0;

   always @(posedge clock) begin
      token_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         checked++;
         if (pending_chars.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected transfer: expected none, actual char %h last %b index %0d",
                     $time, rsp_tdata[7:0], rsp_tlast, rsp_tdata[16:8]);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_tdata[7:0] !== want.ch || rsp_tlast !== want.last ||
                rsp_tdata[16:8] !== want.idx || rsp_tdata[23:17] !== '0) begin
               fail_count++;
               $display("%0t: mismatch: expected char %h last %b index %0d pad 00, %s",
                        $time, want.ch, want.last, want.idx, "see actual below");
               $display("%0t:          actual   char %h last %b index %0d pad %h",
                        $time, rsp_tdata[7:0], rsp_tlast, rsp_tdata[16:8], rsp_tdata[23:17]);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Receiver back-pressure: pick a new random pattern whenever the tick's low bits wrap to zero.
   // ---------------------------------------------------------------------------------
   ready_mode_type ready_mode = READY_ALWAYS;
   logic [7:0]     ready_tick = '0;

   always @(posedge clock) begin
      ready_tick <= ready_tick + 8'd1;
      if (ready_tick[5:0] == 6'd0) ready_mode <= ready_mode_type'($urandom_range(0, 3));
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         READY_RUNS:   if ($urandom_range(0, 7) == 0) rsp_tready <= ~rsp_tready;
         default:      rsp_tready <= ready_tick[1];
      endcase
   end

   // ---------------------------------------------------------------------------------
   // Watchdog: count cycles in which no transfer of any kind happens.
   // ---------------------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("%0t: no transfer for %0d cycles, %0d characters still owed",
               $time, IDLE_LIMIT, pending_chars.size());
      $display("FAIL text_tokenizer_stopword_stemmer_core");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Sender: bytes go out in bursts of random length separated by random gaps.
   // ---------------------------------------------------------------------------------
   int  burst_left = 8;
   int  sent_bytes = 0;
   int  settings_count = 0;
   bit  typed_row = 1'b0;   // hold back model output while a typed row is in flight
   stim_row_type rows [$];

   task automatic push_byte(input char_type c, input logic ns);
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= ns;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // transfer accepted at this edge
      tokenize_byte(c, ns);
      if (!typed_row)
         foreach (step_out[k]) pending_chars.push_back(step_out[k]);
      sent_bytes++;
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
         burst_left = $urandom_range(1, 28);
      end
   endtask

   // Stop sending, wait for every owed character, then let any silent byte finish.
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic char_type pick_delim();
      char_type d;
      do d = 8'($urandom_range(0, 255)); while (word_char(d));
      return d;
   endfunction

   // csr transfers leave psel/penable up; the caller releases them or starts another.
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_LOWERCASE: fold_on   = value[0];
         REG_STOP:      filter_on = value[0];
         REG_STEM:      stem_on   = value[0];
         default: ;
      endcase
   endtask

   task automatic csr_read(input logic [1:0] idx, output logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      value = csr_prdata;
   endtask

   task automatic csr_release();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Read all three registers back and compare with the model's settings.
   task automatic check_regs();
      logic [31:0] got;
      logic [31:0] want;
      logic [1:0]  order [3];
      order = '{REG_LOWERCASE, REG_STOP, REG_STEM};
      foreach (order[r]) begin
         csr_read(order[r], got);
         case (order[r])
            REG_LOWERCASE: want = {31'b0, fold_on};
            REG_STOP:      want = {31'b0, filter_on};
            default:       want = {31'b0, stem_on};
         endcase
         if (got !== want) begin
            fail_count++;
            $display("%0t: register %0d readback: expected %h, actual %h",
                     $time, order[r], want, got);
         end
      end
   endtask

   // bits: [0] lowercase, [1] stop filter, [2] stem.  Upper write bits are noise.
   task automatic apply_settings(input logic [2:0] bits);
      quiesce();
      csr_write(REG_LOWERCASE, ($urandom() << 1) | bits[0]);
      csr_write(REG_STOP,      ($urandom() << 1) | bits[1]);
      csr_write(REG_STEM,      ($urandom() << 1) | bits[2]);
      csr_write(REG_SPARE,     $urandom());
      check_regs();
      csr_release();
      settings_count++;
   endtask

   task automatic add_row(input bit ns, input int cfg, input char_type fill, input int fill_n,
                          input string text, input int tail, input bit typed,
                          input string want, input int want_idx);
      rows.push_back('{ns, cfg, fill, fill_n, text, tail, typed, want, want_idx});
   endtask

   // Mostly words (stop words, suffixed stems, long runs) with mixed case and odd
   // delimiters; some raw noise bytes and the odd new_set landing mid-word.
   task automatic send_prose(input int budget);
      char_type word [$];
      int       sent;
      int       pick;
      int       len;
      string    sw;
      sent = 0;
      while (sent < budget) begin
         word.delete();
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            word.push_back(8'($urandom_range(0, 255)));
         end else begin
            if (pick < 40) begin
               sw = stop_vocab[$urandom_range(0, 7)];
               for (int i = 0; i < sw.len(); i++) word.push_back(sw[i]);
            end else if (pick < 44) begin
               len = $urandom_range(58, 70);
               repeat (len) word.push_back(CH_LC_A + 8'($urandom_range(0, 25)));
            end else begin
               len = $urandom_range(1, 6);
               repeat (len)
                  word.push_back(($urandom_range(0, 4) == 0) ?
                                 CH_0 + 8'($urandom_range(0, 9)) :
                                 CH_LC_A + 8'($urandom_range(0, 25)));
               sw = suffixes[$urandom_range(0, 4)];
               for (int i = 0; i < sw.len(); i++) word.push_back(sw[i]);
            end
            foreach (word[i])
               if (word[i] inside {[CH_LC_A:CH_LC_Z]} && $urandom_range(0, 4) == 0)
                  word[i] = word[i] - CASE_OFFSET;
            word.push_back(($urandom_range(0, 9) == 0) ? 8'h00 : pick_delim());
            if ($urandom_range(0, 7) == 0) word.push_back(pick_delim());
         end
         foreach (word[i]) push_byte(word[i], $urandom_range(0, 59) == 0);
         sent += word.size();
         // now and then hold the sender until the core has paid out everything
         if ($urandom_range(0, 29) == 0) quiesce();
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------------------
   initial begin : stimulus
      bit       first;
      logic [2:0] phase_bits [4];
      stop_vocab = '{"the", "is", "a", "an", "and", "in", "of", "to"};
      suffixes   = '{"ing", "ed", "s", "", "es"};
      tok_len    = 0;
      raw_count  = 0;
      kept_count = 0;
      fold_on    = 1'b1;
      filter_on  = 1'b1;
      stem_on    = 1'b1;

      // Directed table.  Typed rows: result read straight off the rules.
      //      ns cfg       fill fill_n  text             tail      typed want     idx
      add_row(1, CFG_KEEP, 0,   0,      "Hello ",        NO_END,   1,    "hello", 0);
      add_row(0, CFG_KEEP, 0,   0,      "the ",          NO_END,   1,    "",      0);
      add_row(0, CFG_KEEP, 0,   0,      "a",             8'h00,    1,    "",      0);
      add_row(0, CFG_KEEP, 0,   0,      "walking ",      NO_END,   1,    "walk",  1);
      add_row(0, CFG_KEEP, 0,   0,      "jumped,",       NO_END,   1,    "jump",  2);
      add_row(0, CFG_KEEP, 0,   0,      "cats.",         NO_END,   1,    "cat",   3);
      add_row(0, CFG_KEEP, 0,   0,      "s ",            NO_END,   1,    "s",     4);
      add_row(0, CFG_KEEP, 0,   0,      "ed ",           NO_END,   1,    "ed",    5);
      add_row(0, CFG_KEEP, 0,   0,      "ing ",          NO_END,   1,    "ing",   6);
      add_row(0, CFG_KEEP, 0,   0,      " ",             NO_END,   1,    "",      0);
      add_row(0, CFG_KEEP, 0,   0,      "Z9z0",          8'hFF,    1,    "z9z0",  7);
      // delimiters hugging the letter and digit ranges
      add_row(0, CFG_KEEP, 0,   0,      "@x[y{w/v:u",    8'h60,    0,    "",      0);
      add_row(0, CFG_KEEP, 0,   0,      "q",             8'h80,    0,    "",      0);
      add_row(0, CFG_KEEP, 0,   0,      "r",             8'h7F,    0,    "",      0);
      // overlong: only the first 63 characters count, so the ing inside is stripped
      add_row(0, CFG_KEEP, "b", 60,     "ingqqqqq ",     NO_END,   0,    "",      0);
      // case folding off: upper case neither matches a stop word nor loses a suffix
      add_row(0, 3'b110,   0,   0,      "The THE RUNS a ", NO_END, 0,    "",      0);
      add_row(0, 3'b001,   0,   0,      "And running is ", NO_END, 0,    "",      0);
      add_row(0, 3'b000,   0,   0,      "Dogs xyz",      NO_END,   0,    "",      0);
      // new_set on a delimiter throws the partial token away
      add_row(1, CFG_KEEP, 0,   0,      " ",             NO_END,   1,    "",      0);
      add_row(0, CFG_KEEP, 0,   0,      "pqr",           NO_END,   0,    "",      0);
      add_row(1, CFG_KEEP, 0,   0,      "de ",           NO_END,   1,    "de",    0);
      add_row(0, 3'b111,   0,   0,      "ringing sing ", NO_END,   0,    "",      0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // all three registers come out of reset set
      check_regs();
      csr_release();

      foreach (rows[i]) begin
         if (rows[i].cfg != CFG_KEEP) apply_settings(3'(rows[i].cfg));
         typed_row = rows[i].typed;
         // owe the typed result up front so a burst gap cannot outrun it
         if (typed_row)
            for (int k = 0; k < rows[i].want.len(); k++)
               pending_chars.push_back('{rows[i].want[k], k == rows[i].want.len() - 1,
                                         9'(rows[i].want_idx)});
         first = rows[i].ns;
         for (int f = 0; f < rows[i].fill_n; f++) begin
            push_byte(rows[i].fill, first);
            first = 1'b0;
         end
         for (int t = 0; t < rows[i].text.len(); t++) begin
            push_byte(rows[i].text[t], first);
            first = 1'b0;
         end
         if (rows[i].tail != NO_END) push_byte(8'(rows[i].tail), first);
         typed_row = 1'b0;
      end

      // Random prose under all-off, all-on and two random settings.
      phase_bits = '{3'b000, 3'b111, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))};
      foreach (phase_bits[p]) begin
         apply_settings(phase_bits[p]);
         send_prose(18);
      end

      quiesce();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d bytes under %0d csr settings, %0d result transfers checked,",
               sent_bytes, settings_count, checked);
      $display("including stop words, suffixes, overlong tokens, case folding and new_set.");
      if (fail_count == 0) begin
         $display("PASS text_tokenizer_stopword_stemmer_core");
      end else begin
         $display("%0d failures", fail_count);
         $display("FAIL text_tokenizer_stopword_stemmer_core");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/tts_pkg.sv
rtl/tts_cell.sv
rtl/text_tokenizer_stopword_stemmer_core.sv
rtl/tts_checker.sv
tb/tb_text_tokenizer_stopword_stemmer_core.sv
